>>> src/lwc_pkg.sv
package lwc_pkg;
  localparam int unsigned DefMaxSets    = 256;
  localparam int unsigned DefMaxWays    = 8;
  localparam int unsigned DefAddrBits   = 48;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 5;
  localparam logic [CfgIdxW-1:0] RegSetBits = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWays    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOffBits = 2'd2;
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdStore = 1'b1;
  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
  localparam logic [11:0] DirtyLinesMax = 12'hFFF;
  localparam logic [27:0] DirtyBytesMax = 28'hFFF_FFFF;
  localparam logic [47:0] EvictBytesMax = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
    logic [27:0] dirty_bytes_now;
    logic [47:0] dirty_evicted_bytes;
    logic        was_hit;
    logic        was_eviction;
    logic        was_dirty_eviction;
  } result_t;
endpackage

>>> src/lwc_if.sv
interface lwc_access_if #(parameter int unsigned AddrBits = 48);
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [AddrBits-1:0] access_address;
  modport source (output valid, cmd, access_address, input ready);
  modport sink (input valid, cmd, access_address, output ready);
endinterface

interface lwc_result_if;
  logic        valid;
  logic        ready;
  logic        was_hit;
  logic        was_eviction;
  logic        was_dirty_eviction;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;
  logic [27:0] dirty_bytes_now;
  logic [47:0] dirty_evicted_bytes;
  modport source (output valid, was_hit, was_eviction, was_dirty_eviction, hit_total,
                  miss_total, eviction_total, dirty_bytes_now, dirty_evicted_bytes,
                  input ready);
  modport sink (input valid, was_hit, was_eviction, was_dirty_eviction, hit_total,
                miss_total, eviction_total, dirty_bytes_now, dirty_evicted_bytes,
                output ready);
endinterface

>>> src/lwc_front.sv
module lwc_front import lwc_pkg::*; #(
  parameter int unsigned MaxSets  = DefMaxSets,
  parameter int unsigned AddrBits = DefAddrBits,
  localparam int unsigned SetW = (MaxSets > 1) ? $clog2(MaxSets) : 1,
  localparam int unsigned MaxS = $clog2(MaxSets + 1) - 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [3:0]          set_bits_i,
  input  logic [4:0]          off_bits_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_cmd_i,
  input  logic [AddrBits-1:0] in_addr_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output logic                q_store_o,
  output logic [SetW-1:0]     q_set_o,
  output logic [AddrBits-1:0] q_tag_o
);
  // two-entry queue of classified accesses
  logic [1:0]               vld_q;
  logic [1:0]               st_q;
  logic [1:0][SetW-1:0]     set_q;
  logic [1:0][AddrBits-1:0] tag_q;
  logic [3:0]               s_eff;
  logic [AddrBits-1:0]      shifted, set_full, tag_c;
  logic                     push, pop;

  always_comb begin
    s_eff = (32'(set_bits_i) > MaxS) ? 4'(MaxS) : set_bits_i;
    shifted = in_addr_i >> off_bits_i;
    set_full = shifted & ~({AddrBits{1'b1}} << s_eff);
    tag_c = shifted >> s_eff;
  end

  assign in_ready_o = !vld_q[1];
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = vld_q[0];
  assign pop = vld_q[0] && q_ready_i;
  assign q_store_o = st_q[0];
  assign q_set_o = set_q[0];
  assign q_tag_o = tag_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 2'b00;
    end else begin
      case ({push, pop})
        2'b10: if (vld_q[0]) vld_q[1] <= 1'b1; else vld_q[0] <= 1'b1;
        2'b01: vld_q <= {1'b0, vld_q[1]};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && (pop || !vld_q[0])) begin
      st_q[0] <= in_cmd_i; set_q[0] <= SetW'(set_full); tag_q[0] <= tag_c;
    end else if (pop) begin
      st_q[0] <= st_q[1]; set_q[0] <= set_q[1]; tag_q[0] <= tag_q[1];
    end
    if (push && !pop && vld_q[0]) begin
      st_q[1] <= in_cmd_i; set_q[1] <= SetW'(set_full); tag_q[1] <= tag_c;
    end
  end
endmodule

>>> src/lwc_back.sv
module lwc_back import lwc_pkg::*; #(
  parameter int unsigned MaxSets  = DefMaxSets,
  parameter int unsigned MaxWays  = DefMaxWays,
  parameter int unsigned AddrBits = DefAddrBits,
  localparam int unsigned SetW  = (MaxSets > 1) ? $clog2(MaxSets) : 1,
  localparam int unsigned RankW = (MaxWays > 1) ? $clog2(MaxWays) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [3:0]          ways_i,
  input  logic [4:0]          off_bits_i,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  logic                q_store_i,
  input  logic [SetW-1:0]     q_set_i,
  input  logic [AddrBits-1:0] q_tag_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output result_t             res_o
);
  // one memory row per set: valid, dirty, rank and tag of every way
  typedef struct packed {
    logic [MaxWays-1:0]                valid;
    logic [MaxWays-1:0]                dirty;
    logic [MaxWays-1:0][RankW-1:0]     rank;
    logic [MaxWays-1:0][AddrBits-1:0]  tags;
  } row_t;

  row_t                line_mem [MaxSets];
  row_t                rd_row, wr_row;

  logic              busy_q;
  logic              clr_busy_q;
  logic [SetW-1:0]   clr_idx_q;
  logic              st_q;
  logic [SetW-1:0]   set_q;
  logic [AddrBits-1:0] tag_q;
  logic [31:0]       hit_q, miss_q, evc_q, devc_q;
  logic [11:0]       dlines_q;
  logic              out_vld_q;
  result_t           out_q;

  // hold off accesses while the clearing pass runs after reset
  assign q_ready_o = !clr_busy_q && !busy_q && !(out_vld_q && !res_ready_i);
  assign res_valid_o = out_vld_q;
  assign res_o = out_q;

  // stage 1: read the set
  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) begin
      rd_row <= line_mem[q_set_i];
      st_q <= q_store_i; set_q <= q_set_i; tag_q <= q_tag_i;
    end
  end

  logic [3:0]            nways;
  logic [MaxWays-1:0]    vrow, drow, inuse, match, inval;
  logic [MaxWays-1:0][RankW-1:0] rrow;
  logic                  hit, evict, devict;
  logic [RankW-1:0]      way, best;
  logic                  fnd;
  logic [RankW:0]        old;
  logic [31:0]           hit_n, miss_n, evc_n, devc_n;
  logic [11:0]           dl_n;
  logic [43:0]           dbytes;
  logic [79:0]           ebytes;

  always_comb begin
    nways = (ways_i == 4'd0) ? 4'd1 : ((32'(ways_i) > MaxWays) ? 4'(MaxWays) : ways_i);
    vrow = rd_row.valid; drow = rd_row.dirty; rrow = rd_row.rank;
    for (int w = 0; w < MaxWays; w++) begin
      inuse[w] = 32'(w) < 32'(nways);
      match[w] = inuse[w] && vrow[w] && rd_row.tags[w] == tag_q;
      inval[w] = inuse[w] && !vrow[w];
    end
    hit = |match; way = '0; fnd = 1'b0;
    for (int w = 0; w < MaxWays; w++)
      if (!fnd && match[w]) begin way = RankW'(w); fnd = 1'b1; end
    for (int w = 0; w < MaxWays; w++)
      if (!fnd && inval[w]) begin way = RankW'(w); fnd = 1'b1; end
    best = '0;
    for (int w = 1; w < MaxWays; w++)
      if (inuse[w] && rrow[w] > rrow[best]) best = RankW'(w);
    evict = !fnd;
    if (!fnd) way = best;
    devict = evict && drow[way];
    old = vrow[way] ? {1'b0, rrow[way]} : {(RankW+1){1'b1}};
    hit_n = hit_q; miss_n = miss_q; evc_n = evc_q; devc_n = devc_q; dl_n = dlines_q;
    if (hit) begin if (hit_q != Max32) hit_n = hit_q + 32'd1; end
    else if (miss_q != Max32) miss_n = miss_q + 32'd1;
    if (evict && evc_q != Max32) evc_n = evc_q + 32'd1;
    if (devict) begin
      if (devc_q != Max32) devc_n = devc_q + 32'd1;
      if (dl_n != 12'd0) dl_n = dl_n - 12'd1;
    end
    if (st_q && !(drow[way] && !devict) && dl_n != DirtyLinesMax) dl_n = dl_n + 12'd1;
    dbytes = {32'd0, dl_n} << off_bits_i;
    ebytes = {48'd0, devc_n} << off_bits_i;
    // age the younger lines of the set and make the accessed way most recent
    wr_row = rd_row;
    for (int w = 0; w < MaxWays; w++)
      if (inuse[w] && vrow[w] && RankW'(w) != way && {1'b0, rrow[w]} < old &&
          rrow[w] != RankW'(MaxWays - 1))
        wr_row.rank[w] = rrow[w] + RankW'(1);
    wr_row.rank[way] = '0;
    wr_row.valid[way] = 1'b1;
    wr_row.dirty[way] = st_q || (drow[way] && !devict);
    wr_row.tags[way] = tag_q;
  end

  // stage 2: write back the set and the result; clear rows after reset
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      line_mem[clr_idx_q] <= '0;
    end else if (busy_q) begin
      line_mem[set_q] <= wr_row;
    end
    if (busy_q) begin
      out_q.was_hit <= hit;
      out_q.was_eviction <= evict;
      out_q.was_dirty_eviction <= devict;
      out_q.hit_total <= hit_n;
      out_q.miss_total <= miss_n;
      out_q.eviction_total <= evc_n;
      out_q.dirty_bytes_now <= (|dbytes[43:28]) ? DirtyBytesMax : dbytes[27:0];
      out_q.dirty_evicted_bytes <= (|ebytes[79:48]) ? EvictBytesMax : ebytes[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; out_vld_q <= 1'b0;
      clr_busy_q <= 1'b1; clr_idx_q <= '0;
      hit_q <= '0; miss_q <= '0; evc_q <= '0; devc_q <= '0; dlines_q <= '0;
    end else begin
      if (clr_busy_q) begin
        if (clr_idx_q == SetW'(MaxSets - 1)) clr_busy_q <= 1'b0;
        else clr_idx_q <= clr_idx_q + SetW'(1);
      end
      if (out_vld_q && res_ready_i) out_vld_q <= 1'b0;
      if (q_valid_i && q_ready_o) busy_q <= 1'b1;
      if (busy_q) begin
        busy_q <= 1'b0; out_vld_q <= 1'b1;
        hit_q <= hit_n; miss_q <= miss_n; evc_q <= evc_n; devc_q <= devc_n;
        dlines_q <= dl_n;
      end
    end
  end
endmodule

>>> src/lru_writeback_cache_model.sv
// Set-associative write-back LRU cache model. Each access transaction yields one result
// transaction carrying hit/eviction flags and saturating running totals. The front
// splits the address into set and tag and queues up to two transactions; the back
// reads the set's line row into a register, then writes the updated row back and registers the
// result; it takes no new access while busy or while an unaccepted result waits. Valid,
// dirty, rank and tag of every way share one memory row per set; after reset a clearing
// pass zeroes every row (MaxSets rows, 256 by default), and the back takes no access
// until it ends (the front may still queue two). Configure only while idle.
module lru_writeback_cache_model import lwc_pkg::*; #(
  parameter int unsigned MaxSets  = DefMaxSets,
  parameter int unsigned MaxWays  = DefMaxWays,
  parameter int unsigned AddrBits = DefAddrBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lwc_access_if.sink          acc,
  lwc_result_if.source        res
);
  localparam int unsigned SetW = (MaxSets > 1) ? $clog2(MaxSets) : 1;

  logic [3:0] set_bits_q, ways_q;
  logic [4:0] off_bits_q;

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 4'd0; ways_q <= 4'd1; off_bits_q <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSetBits: set_bits_q <= cfg_data_i[3:0];
        RegWays:    ways_q <= cfg_data_i[3:0];
        RegOffBits: off_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                q_valid, q_ready, q_store;
  logic [SetW-1:0]     q_set;
  logic [AddrBits-1:0] q_tag;
  result_t             r;

  lwc_front #(.MaxSets(MaxSets), .AddrBits(AddrBits)) u_front (
    .clk_i, .rst_ni, .set_bits_i(set_bits_q), .off_bits_i(off_bits_q),
    .in_valid_i(acc.valid), .in_ready_o(acc.ready), .in_cmd_i(acc.cmd),
    .in_addr_i(acc.access_address), .q_valid_o(q_valid), .q_ready_i(q_ready),
    .q_store_o(q_store), .q_set_o(q_set), .q_tag_o(q_tag)
  );

  lwc_back #(.MaxSets(MaxSets), .MaxWays(MaxWays), .AddrBits(AddrBits)) u_back (
    .clk_i, .rst_ni, .ways_i(ways_q), .off_bits_i(off_bits_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_store_i(q_store), .q_set_i(q_set),
    .q_tag_i(q_tag), .res_valid_o(res.valid), .res_ready_i(res.ready), .res_o(r)
  );

  assign res.was_hit = r.was_hit;
  assign res.was_eviction = r.was_eviction;
  assign res.was_dirty_eviction = r.was_dirty_eviction;
  assign res.hit_total = r.hit_total;
  assign res.miss_total = r.miss_total;
  assign res.eviction_total = r.eviction_total;
  assign res.dirty_bytes_now = r.dirty_bytes_now;
  assign res.dirty_evicted_bytes = r.dirty_evicted_bytes;
endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lwc_pkg::*;

  // Tracks the cache contents and totals and holds the results still to come.
  class cache_scoreboard;
    bit          line_valid_q [256][8];
    bit          line_dirty_q [256][8];
    logic [47:0] line_tag_q   [256][8];
    logic [2:0]  line_rank_q  [256][8];
    logic [31:0] hits, misses, evictions, devict_count;
    logic [11:0] dirty_lines;
    logic [3:0]  set_bits;
    logic [3:0]  ways_cfg;
    logic [4:0]  offset_bits;
    result_t     pending_results[$];
    int          errors;

    function new();
      foreach (line_valid_q[i, j]) begin
        line_valid_q[i][j] = 1'b0;
        line_dirty_q[i][j] = 1'b0;
        line_tag_q[i][j]   = '0;
        line_rank_q[i][j]  = '0;
      end
      hits = '0; misses = '0; evictions = '0; devict_count = '0;
      dirty_lines = '0;
      set_bits = 4'd0; ways_cfg = 4'd1; offset_bits = 5'd0;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegSetBits: set_bits    = data[3:0];
        RegWays:    ways_cfg    = data[3:0];
        RegOffBits: offset_bits = data;
        default: ;
      endcase
    endfunction

    function logic [31:0] sat_inc(logic [31:0] v);
      return (v == Max32) ? v : v + 32'd1;
    endfunction

    // Predict the result of one accepted access and queue it.
    function void note_access(logic cmd, logic [47:0] addr);
      int          s, b, ways, set, way, best, old_rank;
      logic [47:0] tag;
      logic [63:0] bytes;
      bit          found;
      result_t     r;
      s    = (set_bits > 8) ? 8 : set_bits;
      b    = offset_bits;
      ways = (ways_cfg == 0) ? 1 : ((ways_cfg > 8) ? 8 : ways_cfg);
      set  = int'((addr >> b) & ((48'd1 << s) - 48'd1));
      tag  = addr >> (b + s);
      r    = '0;
      way  = 0;
      found = 1'b0;
      for (int w = 0; w < ways && !found; w++) begin
        if (line_valid_q[set][w] && line_tag_q[set][w] == tag) begin
          way = w; found = 1'b1; r.was_hit = 1'b1;
        end
      end
      for (int w = 0; w < ways && !found; w++) begin
        if (!line_valid_q[set][w]) begin
          way = w; found = 1'b1;
        end
      end
      if (!found) begin
        // Replace the oldest line, lowest way on a tie.
        best = 0;
        for (int w = 1; w < ways; w++)
          if (line_rank_q[set][w] > line_rank_q[set][best]) best = w;
        way = best;
        r.was_eviction = 1'b1;
        if (line_dirty_q[set][way]) begin
          r.was_dirty_eviction = 1'b1;
          devict_count = sat_inc(devict_count);
          if (dirty_lines != 0) dirty_lines--;
          line_dirty_q[set][way] = 1'b0;
        end
        evictions = sat_inc(evictions);
      end
      if (r.was_hit) hits = sat_inc(hits);
      else misses = sat_inc(misses);
      old_rank = line_valid_q[set][way] ? line_rank_q[set][way] : 255;
      for (int w = 0; w < ways; w++) begin
        if (w != way && line_valid_q[set][w] &&
            line_rank_q[set][w] < old_rank && line_rank_q[set][w] < 3'd7)
          line_rank_q[set][w]++;
      end
      line_rank_q[set][way]  = '0;
      line_valid_q[set][way] = 1'b1;
      line_tag_q[set][way]   = tag;
      if (cmd == CmdStore) begin
        if (!line_dirty_q[set][way] && dirty_lines < DirtyLinesMax) dirty_lines++;
        line_dirty_q[set][way] = 1'b1;
      end
      r.hit_total      = hits;
      r.miss_total     = misses;
      r.eviction_total = evictions;
      bytes = 64'(dirty_lines) << b;
      r.dirty_bytes_now = (bytes > 64'(DirtyBytesMax)) ? DirtyBytesMax : bytes[27:0];
      bytes = 64'(devict_count) << b;
      r.dirty_evicted_bytes = (bytes > 64'(EvictBytesMax)) ? EvictBytesMax : bytes[47:0];
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("was_hit", 64'(want.was_hit), 64'(got.was_hit));
      compare_field("was_eviction", 64'(want.was_eviction), 64'(got.was_eviction));
      compare_field("was_dirty_eviction", 64'(want.was_dirty_eviction),
                    64'(got.was_dirty_eviction));
      compare_field("hit_total", 64'(want.hit_total), 64'(got.hit_total));
      compare_field("miss_total", 64'(want.miss_total), 64'(got.miss_total));
      compare_field("eviction_total", 64'(want.eviction_total), 64'(got.eviction_total));
      compare_field("dirty_bytes_now", 64'(want.dirty_bytes_now),
                    64'(got.dirty_bytes_now));
      compare_field("dirty_evicted_bytes", 64'(want.dirty_evicted_bytes),
                    64'(got.dirty_evicted_bytes));
    endfunction
  endclass

  localparam int CycleLimit = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int                  cycle_count = 0;
  cache_scoreboard     sb;

  lwc_access_if #(.AddrBits(48)) acc_if();
  lwc_result_if                  res_if();

  lru_writeback_cache_model uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .acc(acc_if),
    .res(res_if)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    acc_if.valid = 1'b0;
    acc_if.cmd = CmdLoad;
    acc_if.access_address = '0;
    res_if.ready = 1'b0;
    sb = new();
  end

  // Note accepted accesses before checking results; a result never belongs
  // to an access taken on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (acc_if.valid && acc_if.ready) sb.note_access(acc_if.cmd, acc_if.access_address);
      if (res_if.valid && res_if.ready) begin
        sb.check_result('{hit_total: res_if.hit_total, miss_total: res_if.miss_total,
                          eviction_total: res_if.eviction_total,
                          dirty_bytes_now: res_if.dirty_bytes_now,
                          dirty_evicted_bytes: res_if.dirty_evicted_bytes,
                          was_hit: res_if.was_hit, was_eviction: res_if.was_eviction,
                          was_dirty_eviction: res_if.was_dirty_eviction});
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result sink: switch among random stall patterns, and twice hold off
  // for a long stretch so the cache backs up and stalls its input.
  initial begin
    int rx_cycle;
    int pattern;
    rx_cycle = 0;
    pattern = 0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle % 64 == 0) pattern = int'($urandom_range(0, 3));
      if ((rx_cycle >= 3000 && rx_cycle < 3300) || (rx_cycle >= 12000 && rx_cycle < 12400))
        res_if.ready = 1'b0;
      else begin
        case (pattern)
          0: res_if.ready = 1'b1;
          1: res_if.ready = ($urandom_range(0, 1) == 1);
          2: res_if.ready = ($urandom_range(0, 3) != 0);
          default: res_if.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Offer one access and hold it until taken; leave valid high for bursts.
  task automatic send_access(logic cmd, logic [47:0] addr);
    @(negedge clk_i);
    acc_if.valid = 1'b1;
    acc_if.cmd = cmd;
    acc_if.access_address = addr;
    do @(posedge clk_i); while (!acc_if.ready);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk_i);
    acc_if.valid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Hold the sender until every expected result has come, then let the
  // pipeline settle before anything else happens.
  task automatic drain();
    pause_sender(0);
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(logic [3:0] s, logic [3:0] w, logic [4:0] b);
    drain();
    write_reg(RegSetBits, 5'(s));
    write_reg(RegWays, 5'(w));
    write_reg(RegOffBits, b);
  endtask

  // Build an address from tag, set and offset under the live configuration.
  function automatic logic [47:0] make_addr(logic [47:0] tag, int set, logic [31:0] off);
    int s;
    int b;
    s = (sb.set_bits > 8) ? 8 : sb.set_bits;
    b = sb.offset_bits;
    return 48'((64'(tag) << (b + s)) | (64'(set & ((1 << s) - 1)) << b) |
               (64'(off) & ((64'd1 << b) - 1)));
  endfunction

  // Random traffic: mostly a small pool of tags and sets so lines get reused
  // and evicted, with some fully random addresses to toggle every bit.
  task automatic random_phase(int count);
    int sent;
    int burst;
    logic [47:0] addr;
    sent = 0;
    while (sent < count) begin
      burst = int'($urandom_range(1, 24));
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0)
          addr = 48'({$urandom, $urandom});
        else
          addr = make_addr(48'($urandom_range(0, 5)), int'($urandom_range(0, 3)), $urandom);
        send_access(1'($urandom_range(0, 1)), addr);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender(int'($urandom_range(0, 6)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: one set, one way, no offset bits.
    send_access(CmdLoad, 48'h0);
    send_access(CmdStore, 48'h0);
    send_access(CmdLoad, 48'hFFFF_FFFF_FFFF);
    send_access(CmdStore, 48'hFFFF_FFFF_FFFF);
    send_access(CmdLoad, 48'h0);
    send_access(CmdStore, 48'h8000_0000_0001);

    // Two ways, four sets, 16-byte blocks: fill a set, dirty it, then force
    // LRU evictions both clean and dirty.
    configure(4'd2, 4'd2, 5'd4);
    send_access(CmdStore, make_addr(48'd1, 0, 0));
    send_access(CmdLoad,  make_addr(48'd2, 0, 15));
    send_access(CmdLoad,  make_addr(48'd1, 0, 3));
    send_access(CmdLoad,  make_addr(48'd3, 0, 0));
    send_access(CmdLoad,  make_addr(48'd4, 0, 0));
    send_access(CmdStore, make_addr(48'd4, 0, 0));
    send_access(CmdLoad,  make_addr(48'd5, 0, 0));
    send_access(CmdLoad,  make_addr(48'd6, 0, 0));
    send_access(CmdStore, make_addr(48'd7, 3, 0));
    send_access(CmdLoad,  make_addr(48'd7, 3, 0));

    // Out-of-range registers: too many set bits, zero ways, widest offset.
    configure(4'd15, 4'd0, 5'd31);
    send_access(CmdStore, 48'h0);
    send_access(CmdStore, 48'hFFFF_FFFF_FFFF);
    send_access(CmdLoad,  48'h7FFF_FFFF_FFFF);
    configure(4'd8, 4'd15, 5'd16);
    send_access(CmdStore, 48'h1234_5678_9ABC);
    send_access(CmdLoad,  48'h1234_5678_9ABC);
    pause_sender(0);

    configure(4'd3, 4'd4, 5'd6);   random_phase(230);
    configure(4'd8, 4'd8, 5'd0);   random_phase(230);
    configure(4'd15, 4'd15, 5'd31); random_phase(230);
    configure(4'd1, 4'd0, 5'd16);  random_phase(230);
    configure(4'd5, 4'd3, 5'd2);   random_phase(230);
    configure(4'd0, 4'd8, 5'd12);  random_phase(230);
    configure(4'd2, 4'd2, 5'd5);   random_phase(230);
    configure(4'd1, 4'd1, 5'd0);   random_phase(230);

    drain();
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/lwc_pkg.sv
src/lwc_if.sv
src/lwc_front.sv
src/lwc_back.sv
src/lru_writeback_cache_model.sv
test/testbench.sv
